### rtl/tt_pkg.sv
// Shared constants and types for the text terminal writer.
// Depends on nothing; every other file imports it.
package tt_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] NUL_CHAR     = 8'd0;
	localparam logic [7:0] ATTR_RESET   = 8'd15;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef logic [15:0] cell_t;

endpackage

### rtl/text_terminal_writer.sv
// Text terminal writer top level: sequencer, cursor state and result register.
// Instantiates tt_addr and tt_store; uses tt_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   action, character, read_column, read_row
//   out      output     out_valid / out_ready cell_char, cell_attr, cursor_*
//   cfg      input      cfg_wen               cfg_wdata (text attribute)
//
// After reset the store is cleared one cell a cycle, all COLUMNS*ROWS cells, before in_ready rises.
// A printable character is written at the cursor; an in-range read is issued to the store and
// waits for the registered data; an ignored item or an out-of-range read goes straight to the
// result. A newline clears the bottom row, and a wrap at the last column adds a newline to a
// character; scrolling moves a base row. The store has one write port: one cell write at a time.
// The result waits in an output register; a stalled output holds the sequencer only at its end.
module text_terminal_writer import tt_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  character,
	input  logic [6:0]  read_column,
	input  logic [4:0]  read_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_position
);

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int DEPTH  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_RD_ISSUE = 3'd2;
	localparam logic [2:0] ST_RD_WAIT  = 3'd3;
	localparam logic [2:0] ST_WRITE    = 3'd4;
	localparam logic [2:0] ST_NEWLINE  = 3'd5;
	localparam logic [2:0] ST_CLEAR    = 3'd6;
	localparam logic [2:0] ST_FINISH   = 3'd7;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] init_q;
	logic [COL_W-1:0]  clr_q;
	logic [ROW_W-1:0]  base_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [7:0]        attr_q;
	logic              out_valid_q;

	logic [7:0]        char_q;
	logic [COL_W-1:0]  rcol_q;
	logic [ROW_W-1:0]  rrow_q;
	cell_t             cell_q;

	logic [7:0]        cell_char_q;
	logic [7:0]        cell_attr_q;
	logic [6:0]        cursor_column_q;
	logic [4:0]        cursor_row_q;
	logic [10:0]       cursor_position_q;

	logic              accept;
	logic              rd_ok;
	logic              out_load;
	logic [ROW_W-1:0]  au_row;
	logic [COL_W-1:0]  au_col;
	logic [ADDR_W-1:0] au_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	cell_t             wr_data;
	logic              rd_en;
	cell_t             rd_data;
	logic [ADDR_W-1:0] pos;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_ok    = (32'(read_column) < COLUMNS) && (32'(read_row) < ROWS);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign pos      = ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q);

	always_comb begin
		unique case (state_q)
			ST_RD_ISSUE: begin
				au_row = rrow_q;
				au_col = rcol_q;
			end
			ST_CLEAR: begin
				au_row = ROW_LAST;
				au_col = clr_q;
			end
			default: begin
				au_row = cur_row_q;
				au_col = cur_col_q;
			end
		endcase
	end

	assign wr_en   = (state_q == ST_INIT) || (state_q == ST_WRITE) || (state_q == ST_CLEAR);
	assign wr_addr = (state_q == ST_INIT) ? init_q : au_addr;
	assign wr_data = (state_q == ST_WRITE) ? {attr_q, char_q} : '0;
	assign rd_en   = (state_q == ST_RD_ISSUE);

	tt_addr #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_addr (
		.row (au_row),
		.col (au_col),
		.base(base_q),
		.addr(au_addr)
	);

	tt_store #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(au_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			clr_q       <= '0;
			base_q      <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			attr_q      <= ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				attr_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + ADDR_W'(1);
					if (init_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (action == ACT_READ) begin
							state_q <= rd_ok ? ST_RD_ISSUE : ST_FINISH;
						end else if (character == NUL_CHAR) begin
							state_q <= ST_FINISH;
						end else if (character == NEWLINE_CHAR) begin
							state_q <= ST_NEWLINE;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					state_q <= ST_FINISH;
				end
				ST_WRITE: begin
					if (cur_col_q == COL_LAST) begin
						state_q <= ST_NEWLINE;
					end else begin
						cur_col_q <= cur_col_q + COL_W'(1);
						state_q   <= ST_FINISH;
					end
				end
				ST_NEWLINE: begin
					cur_col_q <= '0;
					clr_q     <= '0;
					if (cur_row_q != ROW_LAST) begin
						cur_row_q <= cur_row_q + ROW_W'(1);
					end else if (base_q == ROW_LAST) begin
						base_q <= '0;
					end else begin
						base_q <= base_q + ROW_W'(1);
					end
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + COL_W'(1);
					if (clr_q == COL_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= character;
			rcol_q <= COL_W'(read_column);
			rrow_q <= ROW_W'(read_row);
			cell_q <= '0;
		end else if (state_q == ST_RD_WAIT) begin
			cell_q <= rd_data;
		end
		if (out_load) begin
			cell_char_q       <= cell_q[7:0];
			cell_attr_q       <= cell_q[15:8];
			cursor_column_q   <= 7'(cur_col_q);
			cursor_row_q      <= 5'(cur_row_q);
			cursor_position_q <= 11'(pos);
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_char       = cell_char_q;
	assign cell_attr       = cell_attr_q;
	assign cursor_column   = cursor_column_q;
	assign cursor_row      = cursor_row_q;
	assign cursor_position = cursor_position_q;

`ifndef SYNTH
	// The cursor and the base row always stay inside the screen.
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_col_q) < COLUMNS) && (32'(cur_row_q) < ROWS) && (32'(base_q) < ROWS))
		else $error("cursor or base row out of range");

	// One item at a time: a transfer in drops ready on the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item taken while one is in work");

	// The store is never written while a cell read is in flight.
	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_ISSUE) |-> !wr_en)
		else $error("store written during a read");
`endif

endmodule

### rtl/tt_addr.sv
// Shared address unit: maps a logical row and column to a cell store address.
// Rows are kept in a circular order starting at the base row. Uses tt_pkg.
module tt_addr import tt_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic [$clog2(ROWS)-1:0]         row,
	input  logic [$clog2(COLUMNS)-1:0]      col,
	input  logic [$clog2(ROWS)-1:0]         base,
	output logic [$clog2(COLUMNS*ROWS)-1:0] addr
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(COLUMNS*ROWS);

	logic [ROW_W:0]   sum;
	logic [ROW_W-1:0] prow;

	always_comb begin
		sum = {1'b0, row} + {1'b0, base};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			prow = ROW_W'(sum - (ROW_W+1)'(ROWS));
		end else begin
			prow = ROW_W'(sum);
		end
		addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	end

endmodule

### rtl/tt_store.sv
// Cell store: one write port and one registered read port.
// Uses the cell type from tt_pkg.
module tt_store import tt_pkg::*; #(
	parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
	parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  cell_t             wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output cell_t             rd_data
);

	cell_t mem [DEPTH];
	cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
